// ----- design/fclk_pkg.sv -----
// Shared types, codes and constants of the fixed-timestep frame clock.
// No dependencies; every other design file but fclk_ram imports this package.
`timescale 1ns / 1ps
`default_nettype none

package fclk_pkg;

    // Request opcodes
    localparam logic [1:0] OP_ADVANCE = 2'd0;
    localparam logic [1:0] OP_CONSUME = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_PENDING = 2'd1;
    localparam logic [1:0] STAT_NO_STEP = 2'd2;

    // Register indexes
    localparam logic [2:0] REG_FIXED_STEP = 3'd0;
    localparam logic [2:0] REG_MAX_DELTA  = 3'd1;
    localparam logic [2:0] REG_TAU        = 3'd2;
    localparam logic [2:0] REG_MAX_STEPS  = 3'd3;
    localparam logic [2:0] REG_TIME_SCALE = 3'd4;
    localparam logic [2:0] REG_PAUSED     = 3'd5;

    // Shared multiplier operand selects
    localparam logic [1:0] MUL_DELTA  = 2'd0;
    localparam logic [1:0] MUL_GAIN   = 2'd1;
    localparam logic [1:0] MUL_SMOOTH = 2'd2;
    localparam logic [1:0] MUL_RUN    = 2'd3;

    // Divider jobs
    localparam logic [1:0] DIV_GAIN  = 2'd0;
    localparam logic [1:0] DIV_STEPS = 2'd1;
    localparam logic [1:0] DIV_ALPHA = 2'd2;

    localparam logic [24:0] TIME_MAX  = 25'd16777216;
    localparam logic [22:0] SCALE_MAX = 23'd6553600;
    localparam logic [16:0] Q16_ONE   = 17'd65536;

    typedef struct packed {
        logic [24:0] fixed_step;
        logic [24:0] max_delta;
        logic [24:0] smoothing_tau;
        logic [15:0] max_steps;
        logic [22:0] time_scale;
        logic        paused;
    } cfg_t;

    typedef struct packed {
        logic       load_in;
        logic       refuse;
        logic       no_step;
        logic       consume;
        logic       clear;
        logic       clamp;
        logic       mul_go;
        logic [1:0] mul_sel;
        logic       acc_upd;
        logic       smooth_load;
        logic       smooth_upd;
        logic       smooth_fin;
        logic       div_go;
        logic [1:0] div_sel;
        logic       run_upd;
        logic       drop_upd;
        logic       alpha_full;
        logic       alpha_fin;
        logic       out_load;
        logic       fill_step;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic       pending_zero;
        logic       have_sample;
        logic       u_zero;
        logic       u_big;
        logic       div_busy;
        logic       fill_last;
        logic       acc_ge_fixed;
        logic       out_busy;
    } dp_stat_t;

    // exp(-x) in Q32 from a Taylor series through the x^12 term, x = y / 2^32
    function automatic logic [63:0] exp_q32(input logic [63:0] y);
        logic [63:0] t;
        logic [63:0] e;
        t = 64'd1 << 32;
        e = t;
        t = ((t * y) >> 32) / 64'd1;  e = e - t;
        t = ((t * y) >> 32) / 64'd2;  e = e + t;
        t = ((t * y) >> 32) / 64'd3;  e = e - t;
        t = ((t * y) >> 32) / 64'd4;  e = e + t;
        t = ((t * y) >> 32) / 64'd5;  e = e - t;
        t = ((t * y) >> 32) / 64'd6;  e = e + t;
        t = ((t * y) >> 32) / 64'd7;  e = e - t;
        t = ((t * y) >> 32) / 64'd8;  e = e + t;
        t = ((t * y) >> 32) / 64'd9;  e = e - t;
        t = ((t * y) >> 32) / 64'd10; e = e + t;
        t = ((t * y) >> 32) / 64'd11; e = e - t;
        t = ((t * y) >> 32) / 64'd12; e = e + t;
        return e;
    endfunction

endpackage

`default_nettype wire

// ----- design/fixed_timestep_frame_clock.sv -----
// Fixed-timestep frame clock: a request stream in, one result per request out.
// s_ channel: s_tuser = opcode (0 advance frame, 1 consume step, 2 clear
// clock), s_tdata = raw_delta and suspend. m_ channel: m_tuser = status,
// m_tdata = deltas, step counts, interpolation alpha and 64-bit totals.
// Registers sit behind the APB port; the user must write them only while
// idle, which the block itself does not enforce. After reset the block
// builds the smoother gain table in RAM and takes no request meanwhile;
// registers return to their reset values and all clock state clears.
// One request at a time goes through the sequencer. Consume, clear, a
// refused advance and opcode three end in the 16-bit alpha division,
// skipped when the accumulator is at or above the fixed step. An advance
// also runs the radix-2 divider for a log2(DEPTH)-bit gain index (only
// when a sample exists and the delta is nonzero and below 16 tau) and a
// 33-bit step count, and uses the shared multiplier up to four times.
// The result waits in an output register; a stalled receiver holds the
// block in its last cycle, while the next request is taken once the
// result is loaded.
// Depends on fclk_pkg, fclk_cfg, fclk_ctrl, fclk_dp and fclk_ram.
`timescale 1ns / 1ps
`default_nettype none

module fixed_timestep_frame_clock
    import fclk_pkg::*;
#(
    parameter int ALPHA_TABLE_DEPTH  = 1024,
    parameter int TIME_FRACTION_BITS = 20
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // Request channel
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [39:0]  s_tdata,   // raw_delta[31:0], suspend[32], zero fill
    input  wire logic [1:0]   s_tuser,   // opcode[1:0]
    // Result channel
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic      [511:0] m_tdata,   // delta_time[30:0], smooth_delta[61:31],
                                         // steps_pending[77:62], steps_dropped[109:78],
                                         // interp_alpha[126:110], frame_count[190:127],
                                         // tick_count[254:191], scaled_total[318:255],
                                         // realtime_total[382:319], fixed_total[446:383],
                                         // dropped_total[510:447], zero fill
    output logic      [1:0]   m_tuser,   // status[1:0]
    // Register port
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready
);

    cfg_t     cfg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    fclk_cfg #(
        .TIME_FRACTION_BITS(TIME_FRACTION_BITS)
    ) u_cfg (
        .aclk   (aclk),
        .aresetn(aresetn),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .cfg    (cfg)
    );

    fclk_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    fclk_dp #(
        .DEPTH(ALPHA_TABLE_DEPTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .cmd         (cmd),
        .stat        (stat),
        .in_opcode   (s_tuser),
        .in_raw_delta(s_tdata[31:0]),
        .in_suspend  (s_tdata[32]),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

`default_nettype wire

// ----- design/fclk_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fclk_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- design/fclk_cfg.sv -----
// APB register file of the frame clock: saturating writes and read-back.
// Depends on fclk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fclk_cfg
    import fclk_pkg::*;
#(
    parameter int TIME_FRACTION_BITS = 20
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output cfg_t             cfg
);

    localparam logic [63:0] ONE_SEC   = 64'd1 << TIME_FRACTION_BITS;
    localparam logic [63:0] FIXED_RAW = ONE_SEC / 60;
    localparam logic [63:0] DELTA_RAW = ONE_SEC / 3;
    localparam logic [63:0] TAU_RAW   = (ONE_SEC + 64'd5) / 10;
    localparam logic [24:0] FIXED_RST = (FIXED_RAW == 0) ? 25'd1 :
        (FIXED_RAW > 64'(TIME_MAX)) ? TIME_MAX : FIXED_RAW[24:0];
    localparam logic [24:0] DELTA_RST = (DELTA_RAW == 0) ? 25'd1 :
        (DELTA_RAW > 64'(TIME_MAX)) ? TIME_MAX : DELTA_RAW[24:0];
    localparam logic [24:0] TAU_RST = (TAU_RAW == 0) ? 25'd1 :
        (TAU_RAW > 64'(TIME_MAX)) ? TIME_MAX : TAU_RAW[24:0];

    cfg_t        cfg_reg;
    logic        wr_en;
    logic [2:0]  idx;
    logic [24:0] time_val;
    logic [22:0] scale_val;

    assign pready = 1'b1;
    assign cfg    = cfg_reg;
    assign idx    = paddr[4:2];
    assign wr_en  = psel & penable & pwrite & pready;

    // Saturate the written value into its legal range
    always_comb begin
        if (pwdata[24:0] == 25'd0) begin
            time_val = 25'd1;
        end else if (pwdata[24:0] > TIME_MAX) begin
            time_val = TIME_MAX;
        end else begin
            time_val = pwdata[24:0];
        end
        scale_val = (pwdata[22:0] > SCALE_MAX) ? SCALE_MAX : pwdata[22:0];
    end

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fixed_step    <= FIXED_RST;
            cfg_reg.max_delta     <= DELTA_RST;
            cfg_reg.smoothing_tau <= TAU_RST;
            cfg_reg.max_steps     <= 16'd8;
            cfg_reg.time_scale    <= 23'(Q16_ONE);
            cfg_reg.paused        <= 1'b0;
        end else if (wr_en) begin
            unique case (idx)
                REG_FIXED_STEP: cfg_reg.fixed_step    <= time_val;
                REG_MAX_DELTA:  cfg_reg.max_delta     <= time_val;
                REG_TAU:        cfg_reg.smoothing_tau <= time_val;
                REG_MAX_STEPS:  cfg_reg.max_steps <=
                    (pwdata[15:0] == 16'd0) ? 16'd1 : pwdata[15:0];
                REG_TIME_SCALE: cfg_reg.time_scale    <= scale_val;
                REG_PAUSED:     cfg_reg.paused        <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read-back
    always_comb begin
        unique case (idx)
            REG_FIXED_STEP: prdata = {7'd0, cfg_reg.fixed_step};
            REG_MAX_DELTA:  prdata = {7'd0, cfg_reg.max_delta};
            REG_TAU:        prdata = {7'd0, cfg_reg.smoothing_tau};
            REG_MAX_STEPS:  prdata = {16'd0, cfg_reg.max_steps};
            REG_TIME_SCALE: prdata = {9'd0, cfg_reg.time_scale};
            REG_PAUSED:     prdata = {31'd0, cfg_reg.paused};
            default:        prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// ----- design/fclk_ctrl.sv -----
// Sequencer of the frame clock: table fill, request decode and the
// step-by-step schedule of the datapath. Depends on fclk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fclk_ctrl
    import fclk_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    localparam logic [4:0] ST_FILL   = 5'd0;
    localparam logic [4:0] ST_IDLE   = 5'd1;
    localparam logic [4:0] ST_DECODE = 5'd2;
    localparam logic [4:0] ST_CLAMP  = 5'd3;
    localparam logic [4:0] ST_MULD   = 5'd4;
    localparam logic [4:0] ST_ACC    = 5'd5;
    localparam logic [4:0] ST_SMSEL  = 5'd6;
    localparam logic [4:0] ST_GDIVGO = 5'd7;
    localparam logic [4:0] ST_GDIV   = 5'd8;
    localparam logic [4:0] ST_GREAD  = 5'd9;
    localparam logic [4:0] ST_GMUL   = 5'd10;
    localparam logic [4:0] ST_SUPD   = 5'd11;
    localparam logic [4:0] ST_SMUL   = 5'd12;
    localparam logic [4:0] ST_SFIN   = 5'd13;
    localparam logic [4:0] ST_NDIVGO = 5'd14;
    localparam logic [4:0] ST_NDIV   = 5'd15;
    localparam logic [4:0] ST_RUN    = 5'd16;
    localparam logic [4:0] ST_DROP   = 5'd17;
    localparam logic [4:0] ST_ALPHA  = 5'd18;
    localparam logic [4:0] ST_ADIV   = 5'd19;
    localparam logic [4:0] ST_AFIN   = 5'd20;
    localparam logic [4:0] ST_OUT    = 5'd21;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.mul_sel = MUL_DELTA;
        cmd.div_sel = DIV_STEPS;
        unique case (state_reg)
            ST_FILL: begin
                cmd.fill_step = 1'b1;
                if (stat.fill_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next = ST_ALPHA;
                case (stat.opcode)
                    OP_ADVANCE: begin
                        if (stat.pending_zero) state_next = ST_CLAMP;
                        else cmd.refuse = 1'b1;
                    end
                    OP_CONSUME: begin
                        if (stat.pending_zero) cmd.no_step = 1'b1;
                        else cmd.consume = 1'b1;
                    end
                    OP_CLEAR: cmd.clear = 1'b1;
                    default: ;
                endcase
            end
            ST_CLAMP: begin
                cmd.clamp  = 1'b1;
                state_next = ST_MULD;
            end
            ST_MULD: begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = MUL_DELTA;
                state_next  = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc_upd = 1'b1;
                state_next  = ST_SMSEL;
            end
            ST_SMSEL: begin
                if (!stat.have_sample) begin
                    cmd.smooth_load = 1'b1;
                    state_next      = ST_SMUL;
                end else if (stat.u_zero) begin
                    state_next = ST_SMUL;
                end else if (stat.u_big) begin
                    state_next = ST_GMUL;
                end else begin
                    state_next = ST_GDIVGO;
                end
            end
            ST_GDIVGO: begin
                cmd.div_go  = 1'b1;
                cmd.div_sel = DIV_GAIN;
                state_next  = ST_GDIV;
            end
            ST_GDIV: begin
                if (!stat.div_busy) state_next = ST_GREAD;
            end
            ST_GREAD: state_next = ST_GMUL;
            ST_GMUL: begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = MUL_GAIN;
                state_next  = ST_SUPD;
            end
            ST_SUPD: begin
                cmd.smooth_upd = 1'b1;
                state_next     = ST_SMUL;
            end
            ST_SMUL: begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = MUL_SMOOTH;
                state_next  = ST_SFIN;
            end
            ST_SFIN: begin
                cmd.smooth_fin = 1'b1;
                state_next     = ST_NDIVGO;
            end
            ST_NDIVGO: begin
                cmd.div_go  = 1'b1;
                cmd.div_sel = DIV_STEPS;
                state_next  = ST_NDIV;
            end
            ST_NDIV: begin
                if (!stat.div_busy) state_next = ST_RUN;
            end
            ST_RUN: begin
                cmd.run_upd = 1'b1;
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = MUL_RUN;
                state_next  = ST_DROP;
            end
            ST_DROP: begin
                cmd.drop_upd = 1'b1;
                state_next   = ST_ALPHA;
            end
            ST_ALPHA: begin
                if (stat.acc_ge_fixed) begin
                    cmd.alpha_full = 1'b1;
                    state_next     = ST_OUT;
                end else begin
                    cmd.div_go  = 1'b1;
                    cmd.div_sel = DIV_ALPHA;
                    state_next  = ST_ADIV;
                end
            end
            ST_ADIV: begin
                if (!stat.div_busy) state_next = ST_AFIN;
            end
            ST_AFIN: begin
                cmd.alpha_fin = 1'b1;
                state_next    = ST_OUT;
            end
            ST_OUT: begin
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State register; reset starts the gain table fill
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_FILL;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/fclk_dp.sv -----
// Datapath of the frame clock: clock state, shared multiplier, radix-2
// divider, gain table generator and RAM, output register.
// Depends on fclk_pkg and fclk_ram.
`timescale 1ns / 1ps
`default_nettype none

module fclk_dp
    import fclk_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire cfg_t          cfg,
    input  wire dp_cmd_t       cmd,
    output dp_stat_t           stat,
    input  wire logic [1:0]    in_opcode,
    input  wire logic [31:0]   in_raw_delta,
    input  wire logic          in_suspend,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic      [511:0]  m_tdata,
    output logic      [1:0]    m_tuser
);

    localparam int AW = $clog2(DEPTH);
    localparam int NW = 25 + AW;
    localparam logic [63:0] Y_Q32 = (64'd16 << 32) / DEPTH;
    localparam logic [63:0] E_FULL = exp_q32(Y_Q32);
    localparam logic [31:0] E_Q32 = E_FULL[31:0];

    // Request and clock state
    logic [1:0]  op_reg;
    logic [31:0] raw_reg;
    logic        susp_reg;
    logic [24:0] u_reg;
    logic        hold_reg;
    logic [49:0] prod_reg;
    logic [32:0] acc_reg;
    logic        have_reg;
    logic [24:0] smooth_reg;
    logic [15:0] pending_reg;
    logic [31:0] step_acc_reg;
    logic [63:0] frames_reg, ticks_reg, scaled_reg, rawsum_reg, fixsum_reg, dropsum_reg;
    logic [30:0] last_delta_reg, last_smooth_reg;
    logic [1:0]  status_reg;
    logic [31:0] drop_out_reg;
    logic [16:0] alpha_reg;

    // Divider
    logic [28:0] rem_reg;
    logic [32:0] qsr_reg;
    logic [28:0] den_reg;
    logic [5:0]  div_cnt_reg;

    // Table fill
    logic [AW-1:0] fill_idx_reg;
    logic [32:0]   gacc_reg;

    // Output register
    logic         m_tvalid_reg;
    logic [511:0] m_data_reg;
    logic [1:0]   m_user_reg;

    logic [24:0] mul_a, mul_b;
    logic [24:0] diff;
    logic        u_ge_s;
    logic [16:0] gain;
    logic [16:0] ram_rdata;
    logic [16:0] fill_gain;
    logic [64:0] gprod;
    logic [32:0] gacc_next;
    logic [15:0] run_c;
    logic [30:0] scaled_c;
    logic [30:0] d_c;
    logic [NW-1:0] gnum;
    logic [30:0] dtrial;
    logic [28:0] rem_step;
    logic [32:0] gross_c;

    // Status to the sequencer
    always_comb begin
        stat.opcode       = op_reg;
        stat.pending_zero = (pending_reg == 16'd0);
        stat.have_sample  = have_reg;
        stat.u_zero       = (u_reg == 25'd0);
        stat.u_big        = ({4'd0, u_reg} >= {cfg.smoothing_tau, 4'd0});
        stat.div_busy     = (div_cnt_reg != 6'd0);
        stat.fill_last    = (fill_idx_reg == AW'(DEPTH - 1));
        stat.acc_ge_fixed = (step_acc_reg >= {7'd0, cfg.fixed_step});
        stat.out_busy     = m_tvalid_reg & ~m_tready;
    end

    // Operand selection for the shared multiplier
    assign u_ge_s = (u_reg >= smooth_reg);
    assign diff   = u_ge_s ? (u_reg - smooth_reg) : (smooth_reg - u_reg);
    assign gain   = stat.u_big ? Q16_ONE : ram_rdata;
    assign run_c  = (qsr_reg > {17'd0, cfg.max_steps}) ? cfg.max_steps : qsr_reg[15:0];

    always_comb begin
        case (cmd.mul_sel)
            MUL_DELTA: begin
                mul_a = u_reg;
                mul_b = {2'd0, cfg.time_scale};
            end
            MUL_GAIN: begin
                mul_a = diff;
                mul_b = {8'd0, gain};
            end
            MUL_SMOOTH: begin
                mul_a = smooth_reg;
                mul_b = {2'd0, cfg.time_scale};
            end
            default: begin
                mul_a = cfg.fixed_step;
                mul_b = {9'd0, run_c};
            end
        endcase
    end

    assign scaled_c = prod_reg[46:16];
    assign d_c      = hold_reg ? 31'd0 : scaled_c;

    // Divider step: one quotient bit per cycle
    assign gnum     = NW'(u_reg) * NW'(DEPTH);
    assign dtrial   = {1'b0, rem_reg, qsr_reg[32]} - {2'd0, den_reg};
    assign rem_step = dtrial[30] ? {rem_reg[27:0], qsr_reg[32]} : dtrial[28:0];
    assign gross_c  = acc_reg - {4'd0, rem_reg};

    // Gain table generator: 65536 - round(65536 * E^k)
    assign fill_gain = Q16_ONE - 17'((gacc_reg + 33'd32768) >> 16);
    assign gprod     = 65'(gacc_reg) * 65'(E_Q32);
    assign gacc_next = 33'((gprod + 65'h80000000) >> 32);

    fclk_ram #(
        .WIDTH(17),
        .DEPTH(DEPTH)
    ) u_gain_ram (
        .aclk (aclk),
        .we   (cmd.fill_step),
        .waddr(fill_idx_reg),
        .wdata(fill_gain),
        .raddr(qsr_reg[AW-1:0]),
        .rdata(ram_rdata)
    );

    // Payload registers without reset
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg   <= in_opcode;
            raw_reg  <= in_raw_delta;
            susp_reg <= in_suspend;
        end
        if (cmd.clamp) begin
            u_reg    <= (raw_reg < {7'd0, cfg.max_delta}) ? raw_reg[24:0] : cfg.max_delta;
            hold_reg <= cfg.paused | susp_reg;
        end
        if (cmd.mul_go) begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.acc_upd) begin
            acc_reg <= {1'b0, step_acc_reg} + {2'd0, d_c};
        end
        if (cmd.div_go) begin
            case (cmd.div_sel)
                DIV_GAIN: begin
                    rem_reg <= {4'd0, gnum[NW-1:AW]};
                    qsr_reg <= {gnum[AW-1:0], {(33 - AW){1'b0}}};
                    den_reg <= {cfg.smoothing_tau, 4'd0};
                end
                DIV_STEPS: begin
                    rem_reg <= 29'd0;
                    qsr_reg <= acc_reg;
                    den_reg <= {4'd0, cfg.fixed_step};
                end
                default: begin
                    rem_reg <= step_acc_reg[28:0];
                    qsr_reg <= 33'd0;
                    den_reg <= {4'd0, cfg.fixed_step};
                end
            endcase
        end else if (div_cnt_reg != 6'd0) begin
            rem_reg <= rem_step;
            qsr_reg <= {qsr_reg[31:0], ~dtrial[30]};
        end
        if (cmd.load_in) begin
            status_reg   <= STAT_OK;
            drop_out_reg <= 32'd0;
        end else if (cmd.refuse) begin
            status_reg <= STAT_PENDING;
        end else if (cmd.no_step) begin
            status_reg <= STAT_NO_STEP;
        end else if (cmd.run_upd) begin
            drop_out_reg <= (qsr_reg[32] || (qsr_reg - {17'd0, run_c}) > 33'hFFFFFFFF) ?
                32'hFFFFFFFF : 32'(qsr_reg - {17'd0, run_c});
        end
        if (cmd.alpha_full) begin
            alpha_reg <= Q16_ONE;
        end else if (cmd.alpha_fin) begin
            alpha_reg <= {1'b0, qsr_reg[15:0]};
        end
        if (cmd.out_load) begin
            m_data_reg <= {1'b0, dropsum_reg, fixsum_reg, rawsum_reg, scaled_reg,
                           ticks_reg, frames_reg, alpha_reg, drop_out_reg,
                           pending_reg, last_smooth_reg, last_delta_reg};
            m_user_reg <= status_reg;
        end
    end

    // Clock state; reset and a clear request both zero it
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            pending_reg     <= 16'd0;
            have_reg        <= 1'b0;
            smooth_reg      <= 25'd0;
            step_acc_reg    <= 32'd0;
            frames_reg      <= 64'd0;
            ticks_reg       <= 64'd0;
            scaled_reg      <= 64'd0;
            rawsum_reg      <= 64'd0;
            fixsum_reg      <= 64'd0;
            dropsum_reg     <= 64'd0;
            last_delta_reg  <= 31'd0;
            last_smooth_reg <= 31'd0;
        end else begin
            if (cmd.consume) begin
                pending_reg <= pending_reg - 16'd1;
                ticks_reg   <= ticks_reg + 64'd1;
                fixsum_reg  <= fixsum_reg + {39'd0, cfg.fixed_step};
            end
            if (cmd.clamp) begin
                rawsum_reg <= rawsum_reg + {32'd0, raw_reg};
                frames_reg <= frames_reg + 64'd1;
            end
            if (cmd.acc_upd) begin
                last_delta_reg <= d_c;
                scaled_reg     <= scaled_reg + {33'd0, d_c};
            end
            if (cmd.smooth_load) begin
                smooth_reg <= u_reg;
                have_reg   <= 1'b1;
            end else if (cmd.smooth_upd) begin
                smooth_reg <= u_ge_s ? smooth_reg + prod_reg[40:16]
                                     : smooth_reg - prod_reg[40:16];
            end
            if (cmd.smooth_fin) begin
                last_smooth_reg <= hold_reg ? 31'd0 : scaled_c;
            end
            if (cmd.run_upd) begin
                pending_reg  <= run_c;
                step_acc_reg <= {3'd0, rem_reg};
            end
            if (cmd.drop_upd) begin
                dropsum_reg <= dropsum_reg + {31'd0, gross_c - prod_reg[32:0]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg  <= 6'd0;
            fill_idx_reg <= '0;
            gacc_reg     <= 33'h100000000;
            m_tvalid_reg <= 1'b0;
        end else begin
            // Load the quotient bit count of the job, else count down
            if (cmd.div_go) begin
                case (cmd.div_sel)
                    DIV_GAIN:  div_cnt_reg <= 6'(AW);
                    DIV_STEPS: div_cnt_reg <= 6'd33;
                    default:   div_cnt_reg <= 6'd16;
                endcase
            end else if (div_cnt_reg != 6'd0) begin
                div_cnt_reg <= div_cnt_reg - 6'd1;
            end
            // Advance the table generator
            if (cmd.fill_step) begin
                fill_idx_reg <= fill_idx_reg + AW'(1);
                gacc_reg     <= gacc_next;
            end
            // Hold the result until taken
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // A new result never overwrites one still waiting
    a_out_safe: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !(m_tvalid_reg && !m_tready))
        else $error("result overwritten while stalled");

    // The divider is idle whenever a job is started
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_go |-> div_cnt_reg == 6'd0)
        else $error("divider restarted while busy");

    // The leftover accumulator is below one fixed step after a frame
    a_acc_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.run_upd |=> step_acc_reg < {7'd0, cfg.fixed_step})
        else $error("accumulator remainder not below fixed step");

    // The smoothed delta stays at or below TIME_MAX
    a_smooth_rng: assert property (@(posedge aclk) disable iff (!aresetn)
        smooth_reg <= TIME_MAX)
        else $error("smoothed delta out of range");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the fixed-timestep frame clock.
// Drives requests and register writes and checks every result against a
// behavioral predictor. Depends on fclk_pkg and the fixed_timestep_frame_clock RTL.
`timescale 1ns / 1ps

module testbench;
    import fclk_pkg::*;

    localparam int TBL_DEPTH = 1024;
    localparam logic [1:0] OP_NOP = 2'd3;   // unused opcode, reports only
    localparam longint CYCLE_LIMIT = 3000000;
    localparam int SETTLE_CYCLES = 100;

    typedef struct {
        logic [1:0]  status;
        logic [30:0] delta_time;
        logic [30:0] smooth_delta;
        logic [15:0] steps_pending;
        logic [31:0] steps_dropped;
        logic [16:0] interp_alpha;
        logic [63:0] frame_count;
        logic [63:0] tick_count;
        logic [63:0] scaled_total;
        logic [63:0] realtime_total;
        logic [63:0] fixed_total;
        logic [63:0] dropped_total;
    } clock_report_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [39:0]  s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [511:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    fixed_timestep_frame_clock uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #6 aclk = ~aclk;

    // Predictor configuration and clock state
    logic [31:0] cfg_fixed, cfg_max_delta, cfg_tau, cfg_max_steps, cfg_scale;
    logic        cfg_paused;
    logic [15:0] clk_pending;
    logic        clk_have;
    logic [31:0] clk_smooth, clk_accum, clk_last_d, clk_last_s;
    logic [63:0] clk_frames, clk_ticks, clk_scaled, clk_raw, clk_fixed, clk_dropped;
    logic [31:0] gain_tbl [TBL_DEPTH];

    clock_report_t expected_reports[$];
    int  errors = 0;
    longint cycles = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  recv_hold_left = 0;

    // Gain table: 1 - exp(-16k/DEPTH) in Q16
    task automatic build_gain_table();
        logic [63:0] y, term, e;
        logic [127:0] acc;
        y = (64'd16 << 32) / TBL_DEPTH;
        term = 64'd1 << 32;
        e = term;
        for (int n = 1; n <= 12; n++) begin
            term = ((term * y) >> 32) / n;
            if (n % 2) e = e - term;
            else e = e + term;
        end
        acc = 128'd1 << 32;
        for (int k = 0; k < TBL_DEPTH; k++) begin
            gain_tbl[k] = 32'd65536 - 32'((acc + 128'd32768) >> 16);
            acc = (acc * e + (128'd1 << 31)) >> 32;
        end
    endtask

    task automatic clear_clock_state();
        clk_pending = 0; clk_have = 0; clk_smooth = 0; clk_accum = 0;
        clk_frames = 0; clk_ticks = 0; clk_scaled = 0; clk_raw = 0;
        clk_fixed = 0; clk_dropped = 0; clk_last_d = 0; clk_last_s = 0;
    endtask

    function automatic logic [31:0] time_clamp(logic [31:0] v);
        logic [31:0] m;
        m = v & 32'h1FFFFFF;
        if (m < 1) return 1;
        if (m > 32'd16777216) return 32'd16777216;
        return m;
    endfunction

    function automatic logic [31:0] apply_scale(logic [31:0] d);
        return 32'((64'(d) * cfg_scale) >> 16);
    endfunction

    // Work out the report one request produces and advance the state
    task automatic predict_report(input logic [1:0] op, input logic [31:0] raw,
                                  input logic susp, output clock_report_t r);
        logic [31:0] u, d, dropped;
        logic        hold;
        logic [63:0] k, g, acc, avail, run, drop, alpha;
        r.status = STAT_OK;
        dropped = 0;
        if (op == OP_ADVANCE) begin
            if (clk_pending != 0) begin
                r.status = STAT_PENDING;
            end else begin
                u = raw < cfg_max_delta ? raw : cfg_max_delta;
                hold = cfg_paused || susp;
                d = hold ? 0 : apply_scale(u);
                if (!clk_have) begin
                    clk_smooth = u;
                    clk_have = 1;
                end else if (u > 0) begin
                    k = (64'(u) * TBL_DEPTH) / (64'd16 * cfg_tau);
                    g = k >= TBL_DEPTH ? 64'd65536 : 64'(gain_tbl[k]);
                    if (u >= clk_smooth)
                        clk_smooth = clk_smooth + 32'((64'(u - clk_smooth) * g) >> 16);
                    else
                        clk_smooth = clk_smooth - 32'((64'(clk_smooth - u) * g) >> 16);
                end
                clk_last_d = d;
                clk_last_s = hold ? 0 : apply_scale(clk_smooth);
                clk_raw += raw;
                clk_scaled += d;
                clk_frames++;
                acc = 64'(clk_accum) + d;
                avail = acc / cfg_fixed;
                run = avail < cfg_max_steps ? avail : 64'(cfg_max_steps);
                drop = avail - run;
                clk_pending = 16'(run);
                clk_accum = 32'(acc - avail * cfg_fixed);
                clk_dropped += 64'(cfg_fixed) * drop;
                dropped = drop > 64'hFFFFFFFF ? 32'hFFFFFFFF : 32'(drop);
            end
        end else if (op == OP_CONSUME) begin
            if (clk_pending == 0) begin
                r.status = STAT_NO_STEP;
            end else begin
                clk_pending--;
                clk_ticks++;
                clk_fixed += cfg_fixed;
            end
        end else if (op == OP_CLEAR) begin
            clear_clock_state();
        end
        alpha = (64'(clk_accum) << 16) / cfg_fixed;
        if (alpha > 64'd65536) alpha = 64'd65536;
        r.delta_time = clk_last_d[30:0];
        r.smooth_delta = clk_last_s[30:0];
        r.steps_pending = clk_pending;
        r.steps_dropped = dropped;
        r.interp_alpha = alpha[16:0];
        r.frame_count = clk_frames;
        r.tick_count = clk_ticks;
        r.scaled_total = clk_scaled;
        r.realtime_total = clk_raw;
        r.fixed_total = clk_fixed;
        r.dropped_total = clk_dropped;
    endtask

    // Cycle counter and timeout
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: random stalls, or a long counted hold-off
    always @(negedge aclk) begin
        if (recv_hold_left > 0) begin
            recv_hold_left = recv_hold_left - 1;
            m_tready = 1'b0;
        end else begin
            m_tready = $urandom_range(99) >= recv_idle_pct;
        end
    end

    task automatic chk(input string name, input logic [63:0] exp_v, input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    // Compare each result with the oldest expectation
    always @(posedge aclk) begin
        clock_report_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_reports.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
            end else begin
                e = expected_reports.pop_front();
                chk("status", e.status, m_tuser);
                chk("delta_time", e.delta_time, m_tdata[30:0]);
                chk("smooth_delta", e.smooth_delta, m_tdata[61:31]);
                chk("steps_pending", e.steps_pending, m_tdata[77:62]);
                chk("steps_dropped", e.steps_dropped, m_tdata[109:78]);
                chk("interp_alpha", e.interp_alpha, m_tdata[126:110]);
                chk("frame_count", e.frame_count, m_tdata[190:127]);
                chk("tick_count", e.tick_count, m_tdata[254:191]);
                chk("scaled_total", e.scaled_total, m_tdata[318:255]);
                chk("realtime_total", e.realtime_total, m_tdata[382:319]);
                chk("fixed_total", e.fixed_total, m_tdata[446:383]);
                chk("dropped_total", e.dropped_total, m_tdata[510:447]);
            end
        end
    end

    // Send one request; valid stays high on return until the next call or drain
    task automatic send_req(input logic [1:0] op, input logic [31:0] raw, input logic susp);
        clock_report_t r;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser = op;
        s_tdata = {7'd0, susp, raw};
        do @(posedge aclk); while (!s_tready);
        predict_report(op, raw, susp, r);
        expected_reports.push_back(r);
    endtask

    // Hold the sender until every result is in, then let the block settle
    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expected_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(negedge aclk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = {idx, 2'b00}; pwdata = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        case (idx)
            REG_FIXED_STEP: cfg_fixed = time_clamp(value);
            REG_MAX_DELTA:  cfg_max_delta = time_clamp(value);
            REG_TAU:        cfg_tau = time_clamp(value);
            REG_MAX_STEPS: begin
                cfg_max_steps = value & 32'hFFFF;
                if (cfg_max_steps == 0) cfg_max_steps = 1;
            end
            REG_TIME_SCALE: begin
                cfg_scale = value & 32'h7FFFFF;
                if (cfg_scale > 32'd6553600) cfg_scale = 32'd6553600;
            end
            REG_PAUSED: cfg_paused = value[0];
            default: ;
        endcase
    endtask

    // Hand out every step still pending
    task automatic consume_all();
        while (clk_pending != 0) send_req(OP_CONSUME, $urandom, 1'($urandom_range(1)));
    endtask

    task automatic test_directed();
        send_req(OP_CONSUME, 32'd0, 1'b0);          // nothing to consume
        send_req(OP_NOP, 32'hFFFFFFFF, 1'b1);
        send_req(OP_ADVANCE, 32'd0, 1'b0);          // first sample of zero
        send_req(OP_ADVANCE, 32'd20000, 1'b0);
        send_req(OP_ADVANCE, 32'd40000, 1'b0);
        send_req(OP_ADVANCE, 32'hFFFFFFFF, 1'b0);   // refused, steps pending
        send_req(OP_ADVANCE, 32'd17476, 1'b0);      // refused, steps pending
        consume_all();
        send_req(OP_CONSUME, 32'd5, 1'b1);
        send_req(OP_ADVANCE, 32'hFFFFFFFF, 1'b1);   // suspended frame
        send_req(OP_ADVANCE, 32'd0, 1'b0);          // zero keeps the smoother
        send_req(OP_ADVANCE, 32'd1, 1'b0);
        consume_all();
        send_req(OP_CLEAR, 32'h12345678, 1'b1);
        send_req(OP_ADVANCE, 32'd30000, 1'b0);
        consume_all();
        drain();
    endtask

    task automatic test_registers();
        // Below-range writes saturate upward, above-range ones downward
        write_reg(REG_MAX_STEPS, 32'd0);
        write_reg(REG_FIXED_STEP, 32'd0);
        write_reg(REG_TAU, 32'd0);
        write_reg(REG_MAX_DELTA, 32'hFFFFFFFF);
        write_reg(REG_TIME_SCALE, 32'hFFFFFFFF);
        send_req(OP_ADVANCE, 32'hFFFFFFFF, 1'b0);
        send_req(OP_ADVANCE, 32'd3, 1'b0);
        consume_all();
        send_req(OP_ADVANCE, 32'hFFFFFFFF, 1'b0);
        consume_all();
        drain();
        // Large step with leftover time, then shrink it so alpha clamps
        write_reg(REG_FIXED_STEP, 32'h1FFFFFF);
        write_reg(REG_TIME_SCALE, 32'd65536);
        write_reg(REG_MAX_STEPS, 32'hFFFF);
        send_req(OP_ADVANCE, 32'd900000, 1'b0);
        consume_all();
        drain();
        write_reg(REG_FIXED_STEP, 32'd1000);
        write_reg(REG_MAX_STEPS, 32'd3);
        send_req(OP_NOP, 32'd0, 1'b0);
        send_req(OP_ADVANCE, 32'd0, 1'b0);
        consume_all();
        drain();
        // Widest step count: full scale on the largest step
        write_reg(REG_FIXED_STEP, 32'd16777216);
        write_reg(REG_MAX_STEPS, 32'd65535);
        write_reg(REG_TIME_SCALE, 32'd6553600);
        write_reg(REG_TAU, 32'h1FFFFFF);
        send_req(OP_ADVANCE, 32'hFFFFFFFF, 1'b0);
        consume_all();
        drain();
        // Paused and zero scale
        write_reg(REG_PAUSED, 32'd1);
        write_reg(REG_FIXED_STEP, 32'd17476);
        send_req(OP_ADVANCE, 32'd50000, 1'b0);
        drain();
        write_reg(REG_PAUSED, 32'd0);
        write_reg(REG_TIME_SCALE, 32'd0);
        send_req(OP_ADVANCE, 32'd50000, 1'b0);
        drain();
    endtask

    task automatic random_config();
        write_reg(REG_FIXED_STEP, $urandom_range(3) == 0 ? $urandom_range(1, 200)
                                                          : $urandom_range(1000, 60000));
        write_reg(REG_MAX_DELTA, $urandom_range(3) == 0 ? $urandom
                                                         : $urandom_range(1, 600000));
        write_reg(REG_TAU, $urandom_range(3) == 0 ? $urandom : $urandom_range(1, 300000));
        write_reg(REG_MAX_STEPS, $urandom_range(1, 12));
        write_reg(REG_TIME_SCALE, $urandom_range(3) == 0 ? $urandom
                                                          : $urandom_range(0, 262144));
        write_reg(REG_PAUSED, 32'($urandom_range(9) == 0));
    endtask

    function automatic logic [31:0] pick_delta();
        case ($urandom_range(2))
            0: return $urandom;
            1: return $urandom_range(0, 2 * cfg_max_delta);
            default: return $urandom_range(0, 3 * cfg_fixed);
        endcase
    endfunction

    // Mostly frames followed by their steps; some partial frames and noise
    task automatic test_traffic(input int n_items);
        int sent;
        int sel;
        int n_take;
        sent = 0;
        while (sent < n_items) begin
            sel = $urandom_range(99);
            if (sel < 75) begin
                send_req(OP_ADVANCE, pick_delta(), $urandom_range(7) == 0);
                sent++;
                n_take = clk_pending;
                if ($urandom_range(4) == 0) n_take = $urandom_range(0, n_take + 1);
                repeat (n_take) begin
                    send_req(OP_CONSUME, $urandom, 1'($urandom_range(1)));
                    sent++;
                end
            end else if (sel < 85) begin
                send_req(OP_CONSUME, $urandom, 1'($urandom_range(1)));
                sent++;
            end else if (sel < 90) begin
                send_req(OP_NOP, $urandom, 1'($urandom_range(1)));
                sent++;
            end else if (sel < 93) begin
                send_req(OP_CLEAR, $urandom, 1'($urandom_range(1)));
                sent++;
            end else begin
                send_req(OP_ADVANCE, pick_delta(), 1'($urandom_range(1)));
                sent++;
            end
        end
        drain();
    endtask

    // Stall the receiver long enough for the block to stop taking requests
    task automatic test_backpressure();
        recv_hold_left = 3000;
        send_req(OP_ADVANCE, 32'd40000, 1'b0);
        repeat (12) send_req(OP_CONSUME, $urandom, 1'b0);
        drain();
    endtask

    initial begin
        build_gain_table();
        cfg_fixed = 17476; cfg_max_delta = 349525; cfg_tau = 104858;
        cfg_max_steps = 8; cfg_scale = 65536; cfg_paused = 0;
        clear_clock_state();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        // gain table build after reset
        repeat (TBL_DEPTH + 100) @(posedge aclk);

        test_directed();
        test_registers();
        send_idle_pct = 38; recv_idle_pct = 61;
        random_config();
        test_traffic(600);
        test_backpressure();
        send_idle_pct = 61; recv_idle_pct = 38;
        random_config();
        test_traffic(600);
        send_idle_pct = 0; recv_idle_pct = 0;
        random_config();
        test_traffic(600);

        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/fclk_pkg.sv
design/fclk_ram.sv
design/fclk_cfg.sv
design/fclk_ctrl.sv
design/fclk_dp.sv
design/fixed_timestep_frame_clock.sv
tb/testbench.sv
